// File: sv/dcc_pkg.sv
// Package for the DCC packet line encoder.
// Holds the item types, command codes, packet constants and config types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dcc_pkg;

    localparam int PREAMBLE_BITS = 12;
    localparam int BODY_BITS     = 28;
    localparam int FRAME_BITS    = PREAMBLE_BITS + BODY_BITS;
    localparam int POS_W         = $clog2(FRAME_BITS);
    localparam int BODY_IDX_W    = $clog2(BODY_BITS);

    localparam logic [7:0] SPEED_CODE_A  = 8'h43;
    localparam logic [7:0] SPEED_CODE_B  = 8'h45;
    localparam logic [7:0] FORWARD_BIT   = 8'h20;
    localparam logic [7:0] STOP_DATA     = 8'h60;
    localparam logic [7:0] IDLE_ADDR     = 8'hFF;
    localparam logic [7:0] IDLE_DATA     = 8'h00;
    localparam logic [7:0] GROUP_ONE_RST = 8'h80;
    localparam logic [7:0] GROUP_TWO_RST = 8'hB0;

    localparam logic [7:0]  LOCO_ADDR_RST = 8'd3;
    localparam logic [15:0] ONE_HALF_RST  = 16'd58;
    localparam logic [15:0] ZERO_HALF_RST = 16'd100;

    localparam logic [3:0] GROUP_ONE_LAST = 4'd4;
    localparam logic [3:0] GROUP_TWO_LAST = 4'd8;
    localparam logic [3:0] GROUP_TWO_BASE = 4'd5;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_FORWARD  = 3'd1,
        CMD_BACKWARD = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_IDLE     = 3'd4,
        CMD_FUNC     = 3'd5
    } dcc_cmd_t;

    typedef enum logic [2:0] {
        REG_LOCO_ADDRESS    = 3'd0,
        REG_SPEED_SELECT    = 3'd1,
        REG_TURNOUT_SWAP    = 3'd2,
        REG_ONE_HALF_TICKS  = 3'd3,
        REG_ZERO_HALF_TICKS = 3'd4
    } dcc_reg_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] repeat_count;
        logic [3:0] func_index;
        logic       func_on;
    } dcc_cmd_item_t;

    typedef struct packed {
        logic track_a;
        logic track_b;
        logic turnout_a;
        logic turnout_b;
        logic busy_res;
        logic cmd_rejected;
    } dcc_res_item_t;

    typedef struct packed {
        logic [7:0]  loco_address;
        logic        speed_select;
        logic        turnout_swap;
        logic [15:0] one_half_ticks;
        logic [15:0] zero_half_ticks;
    } dcc_cfg_t;

endpackage

`default_nettype wire

// File: sv/dcc_packet_line_encoder.sv
// A command item is held in the input register, then its result in the result register.
// Throughput: one item per cycle; a stalled result blocks the input register,
// after which cmd_stall holds off the next item.
// Reset (rst_n, async low): no items held, config registers at defaults; the result item register is not reset.
// Depends on dcc_pkg, dcc_cfg_regs and dcc_core.
`default_nettype none

module dcc_packet_line_encoder
    import dcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire dcc_cmd_item_t cmd_item,
    output logic             res_valid,
    input  wire logic        res_stall,
    output dcc_res_item_t    res_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    dcc_cfg_t      cfg;
    dcc_cmd_item_t item_reg;
    logic          item_valid_reg, item_valid_next;
    logic          res_valid_reg, res_valid_next;
    dcc_res_item_t res_item_reg;
    dcc_res_item_t core_result;
    logic          advance;
    logic          take;

    assign cfg_ready = 1'b1;

    dcc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance   = item_valid_reg & (~res_valid_reg | ~res_stall);
    assign cmd_stall = item_valid_reg & ~advance;
    assign take      = cmd_valid & ~cmd_stall;

    dcc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_comb
    begin
        item_valid_next = take | (item_valid_reg & ~advance);
        res_valid_next  = advance | (res_valid_reg & res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= cmd_item;
        if (advance)
            res_item_reg <= core_result;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

// File: sv/dcc_cfg_regs.sv
// Configuration register file of the DCC encoder.
// Depends on dcc_pkg for the register indexes and the config struct.
`default_nettype none

module dcc_cfg_regs
    import dcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output dcc_cfg_t         cfg
);

    dcc_cfg_t cfg_reg;
    dcc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LOCO_ADDRESS:    cfg_next.loco_address    = cfg_data[7:0];
                REG_SPEED_SELECT:    cfg_next.speed_select    = cfg_data[0];
                REG_TURNOUT_SWAP:    cfg_next.turnout_swap    = cfg_data[0];
                REG_ONE_HALF_TICKS:  cfg_next.one_half_ticks  = cfg_data;
                REG_ZERO_HALF_TICKS: cfg_next.zero_half_ticks = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loco_address    <= LOCO_ADDR_RST;
            cfg_reg.speed_select    <= 1'b0;
            cfg_reg.turnout_swap    <= 1'b0;
            cfg_reg.one_half_ticks  <= ONE_HALF_RST;
            cfg_reg.zero_half_ticks <= ZERO_HALF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/dcc_core.sv
// Packet state and one-item update of the DCC encoder.
// Holds function bits, frame, bit timing and repeat count; computes one result.
// Depends on dcc_pkg.
`default_nettype none

module dcc_core
    import dcc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire dcc_cmd_item_t item,
    input  wire dcc_cfg_t cfg,
    output dcc_res_item_t result
);

    logic [7:0]            group_one_reg, group_one_next;
    logic [7:0]            group_two_reg, group_two_next;
    logic [BODY_BITS-1:0]  frame_reg, frame_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  half_reg, half_next;
    logic [15:0]           tick_reg, tick_next;
    logic [7:0]            repeats_reg, repeats_next;
    logic                  level_reg, level_next;

    logic [7:0]  speed_code;
    logic [7:0]  pkt_addr;
    logic [7:0]  pkt_data;
    logic        load;
    logic        rejected;
    logic        cur_bit;
    logic [POS_W-1:0] body_pos;
    logic [BODY_IDX_W-1:0] body_idx;
    logic [15:0] half_len;
    logic [15:0] tick_inc;
    logic [7:0]  func_mask;
    logic        busy;
    logic        ta;
    logic        tb;

    assign speed_code = cfg.speed_select ? SPEED_CODE_B : SPEED_CODE_A;
    assign body_pos   = pos_reg - POS_W'(PREAMBLE_BITS);
    assign body_idx   = BODY_IDX_W'(POS_W'(BODY_BITS - 1) - body_pos);

    always_comb
    begin
        if (pos_reg < POS_W'(PREAMBLE_BITS))
            cur_bit = 1'b1;
        else
            cur_bit = frame_reg[body_idx];
    end

    always_comb
    begin
        half_len = cur_bit ? cfg.one_half_ticks : cfg.zero_half_ticks;
        if (half_len == 16'd0)
            half_len = 16'd1;
    end

    assign tick_inc = tick_reg + 16'd1;

    always_comb
    begin
        group_one_next = group_one_reg;
        group_two_next = group_two_reg;
        frame_next     = frame_reg;
        pos_next       = pos_reg;
        half_next      = half_reg;
        tick_next      = tick_reg;
        repeats_next   = repeats_reg;
        level_next     = level_reg;
        pkt_addr       = cfg.loco_address;
        pkt_data       = IDLE_DATA;
        load           = 1'b0;
        rejected       = 1'b0;
        func_mask      = 8'd0;

        case (item.cmd)
            CMD_TICK:
            begin
                if (repeats_reg != 8'd0)
                begin
                    if (tick_inc < half_len)
                    begin
                        tick_next = tick_inc;
                    end
                    else
                    begin
                        tick_next = 16'd0;
                        if (!half_reg)
                        begin
                            half_next  = 1'b1;
                            level_next = 1'b1;
                        end
                        else
                        begin
                            half_next  = 1'b0;
                            level_next = 1'b0;
                            if (pos_reg == POS_W'(FRAME_BITS - 1))
                            begin
                                pos_next     = '0;
                                repeats_next = repeats_reg - 8'd1;
                            end
                            else
                            begin
                                pos_next = pos_reg + POS_W'(1);
                            end
                        end
                    end
                end
            end
            CMD_FORWARD:
            begin
                load     = 1'b1;
                pkt_data = speed_code | FORWARD_BIT;
            end
            CMD_BACKWARD:
            begin
                load     = 1'b1;
                pkt_data = speed_code;
            end
            CMD_STOP:
            begin
                load     = 1'b1;
                pkt_data = STOP_DATA;
            end
            CMD_IDLE:
            begin
                load     = 1'b1;
                pkt_addr = IDLE_ADDR;
                pkt_data = IDLE_DATA;
            end
            CMD_FUNC:
            begin
                load = 1'b1;
                if (repeats_reg == 8'd0)
                begin
                    if (item.func_index <= GROUP_ONE_LAST)
                    begin
                        func_mask      = 8'd1 << item.func_index[2:0];
                        group_one_next = item.func_on ? (group_one_reg | func_mask)
                                                      : (group_one_reg & ~func_mask);
                        pkt_data       = group_one_next;
                    end
                    else
                    begin
                        if (item.func_index <= GROUP_TWO_LAST)
                        begin
                            func_mask      = 8'd1 << (item.func_index - GROUP_TWO_BASE);
                            group_two_next = item.func_on ? (group_two_reg | func_mask)
                                                          : (group_two_reg & ~func_mask);
                        end
                        pkt_data = group_two_next;
                    end
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        if (load)
        begin
            if (repeats_reg != 8'd0)
            begin
                rejected       = 1'b1;
                group_one_next = group_one_reg;
                group_two_next = group_two_reg;
            end
            else
            begin
                frame_next   = {1'b0, pkt_addr, 1'b0, pkt_data, 1'b0,
                                pkt_addr ^ pkt_data, 1'b1};
                pos_next     = '0;
                half_next    = 1'b0;
                tick_next    = 16'd0;
                level_next   = 1'b0;
                repeats_next = item.repeat_count;
            end
        end
    end

    assign busy = repeats_next != 8'd0;
    assign ta   = busy & level_next;
    assign tb   = busy & ~level_next;

    always_comb
    begin
        result.track_a      = ta;
        result.track_b      = tb;
        result.turnout_a    = cfg.turnout_swap ? tb : ta;
        result.turnout_b    = cfg.turnout_swap ? ta : tb;
        result.busy_res     = busy;
        result.cmd_rejected = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_one_reg <= GROUP_ONE_RST;
            group_two_reg <= GROUP_TWO_RST;
            pos_reg       <= '0;
            half_reg      <= 1'b0;
            tick_reg      <= 16'd0;
            repeats_reg   <= 8'd0;
            level_reg     <= 1'b0;
        end
        else if (step)
        begin
            group_one_reg <= group_one_next;
            group_two_reg <= group_two_next;
            pos_reg       <= pos_next;
            half_reg      <= half_next;
            tick_reg      <= tick_next;
            repeats_reg   <= repeats_next;
            level_reg     <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            frame_reg <= frame_next;
    end

endmodule

`default_nettype wire

// File: sv/dcc_checker.sv
// Port-level checker for the DCC encoder, bound to the top level.
// Depends on dcc_pkg for the result item type.
`default_nettype none

module dcc_checker
    import dcc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    res_valid,
    input wire logic    res_stall,
    input wire dcc_res_item_t res_item
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result item changed while stalled");

    a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.busy_res |->
            !res_item.track_a && !res_item.track_b &&
            !res_item.turnout_a && !res_item.turnout_b)
        else $error("pins not low while idle");

    a_track_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.busy_res |->
            (res_item.track_a ^ res_item.track_b) &&
            (res_item.turnout_a ^ res_item.turnout_b))
        else $error("pin pair not complementary while busy");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.cmd_rejected |-> res_item.busy_res)
        else $error("rejected item without busy");

endmodule

bind dcc_packet_line_encoder dcc_checker u_dcc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

`default_nettype wire

// File: tb/dcc_packet_line_encoder_test.sv
// Self-checking testbench for the DCC packet line encoder.
// Predicts every result item from its own model of the packet timing and checks it.
// Depends on dcc_pkg and the dcc_packet_line_encoder top level.

module dcc_packet_line_encoder_test;
    import dcc_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TICK_CHUNK = 16;
    localparam int RANDOM_PHASES = 2;
    localparam int HOLD_PHASE = 1;
    localparam int PHASE_ITEMS = 80;
    localparam int LAST_PHASE_TICKS = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    dcc_cmd_item_t cmd_item = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    dcc_res_item_t res_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    dcc_cmd_item_t pending_cmds[$];
    dcc_res_item_t expected_res[$];
    int error_count = 0;

    // line model state
    dcc_cfg_t cfg = '{LOCO_ADDR_RST, 1'b0, 1'b0, ONE_HALF_RST, ZERO_HALF_RST};
    logic [7:0] grp_one = GROUP_ONE_RST;
    logic [7:0] grp_two = GROUP_TWO_RST;
    logic [BODY_BITS-1:0] body = '0;
    int unsigned bit_pos = 0;
    logic half_two = 1'b0;
    logic [15:0] tick_cnt = '0;
    logic [7:0] reps_left = '0;
    logic level = 1'b0;

    // sender and receiver pacing
    int burst_left = 1;
    int gap_left = 0;
    int stall_window = 0;
    int stall_mode = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int holds_done = 0;

    string field_names[$bits(dcc_res_item_t)] =
        '{"track_a", "track_b", "turnout_a", "turnout_b", "busy_res", "cmd_rejected"};

    dcc_packet_line_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic dcc_res_item_t encode_step(dcc_cmd_item_t it);
        dcc_res_item_t r;
        logic [7:0] code;
        logic [7:0] addr;
        logic [7:0] data;
        logic [15:0] half;
        logic bit_now;
        logic rejected;
        logic load;
        logic busy;
        code = cfg.speed_select ? SPEED_CODE_B : SPEED_CODE_A;
        addr = cfg.loco_address;
        data = IDLE_DATA;
        rejected = 1'b0;
        load = 1'b0;
        if (it.cmd == CMD_TICK)
        begin
            if (reps_left != 0)
            begin
                if (bit_pos < PREAMBLE_BITS || bit_pos >= FRAME_BITS)
                    bit_now = 1'b1;
                else
                    bit_now = body[BODY_BITS - 1 - (bit_pos - PREAMBLE_BITS)];
                half = bit_now ? cfg.one_half_ticks : cfg.zero_half_ticks;
                if (half == 0)
                    half = 16'd1;
                tick_cnt++;
                if (tick_cnt >= half)
                begin
                    tick_cnt = '0;
                    if (!half_two)
                    begin
                        half_two = 1'b1;
                        level = 1'b1;
                    end
                    else
                    begin
                        half_two = 1'b0;
                        level = 1'b0;
                        bit_pos++;
                        if (bit_pos >= FRAME_BITS)
                        begin
                            bit_pos = 0;
                            reps_left--;
                        end
                    end
                end
            end
        end
        else if (it.cmd <= CMD_FUNC)
        begin
            if (reps_left != 0)
                rejected = 1'b1;
            else
            begin
                load = 1'b1;
                case (it.cmd)
                    CMD_FORWARD:  data = code | FORWARD_BIT;
                    CMD_BACKWARD: data = code;
                    CMD_STOP:     data = STOP_DATA;
                    CMD_IDLE:
                    begin
                        addr = IDLE_ADDR;
                        data = IDLE_DATA;
                    end
                    default:
                    begin
                        if (it.func_index <= GROUP_ONE_LAST)
                        begin
                            grp_one[it.func_index] = it.func_on;
                            data = grp_one;
                        end
                        else
                        begin
                            if (it.func_index <= GROUP_TWO_LAST)
                                grp_two[it.func_index - GROUP_TWO_BASE] = it.func_on;
                            data = grp_two;
                        end
                    end
                endcase
            end
        end
        if (load)
        begin
            body = {1'b0, addr, 1'b0, data, 1'b0, addr ^ data, 1'b1};
            bit_pos = 0;
            half_two = 1'b0;
            tick_cnt = '0;
            level = 1'b0;
            reps_left = it.repeat_count;
        end
        busy = (reps_left != 0);
        r.track_a = busy & level;
        r.track_b = busy & ~level;
        r.turnout_a = cfg.turnout_swap ? r.track_b : r.track_a;
        r.turnout_b = cfg.turnout_swap ? r.track_a : r.track_b;
        r.busy_res = busy;
        r.cmd_rejected = rejected;
        return r;
    endfunction

    // driver: bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && !cmd_stall)
                expected_res.push_back(encode_step(cmd_item));
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cmd_item <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with a long hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (holds_done < hold_requests)
        begin
            holds_done++;
            hold_left = LONG_HOLD_CYCLES;
            res_stall <= 1'b1;
        end
        else
        begin
            if (stall_window <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_window = $urandom_range(20, 120);
            end
            stall_window--;
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                2:       res_stall <= ($urandom_range(0, 3) != 0);
                default: res_stall <= ~res_stall;
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        dcc_res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_res.size() == 0)
                report_error($sformatf("result item %b with nothing expected", res_item));
            else
            begin
                want = expected_res.pop_front();
                for (int k = 0; k < $bits(dcc_res_item_t); k++)
                    if (res_item[$bits(dcc_res_item_t) - 1 - k]
                            !== want[$bits(dcc_res_item_t) - 1 - k])
                        report_error($sformatf("%s: got %b, expected %b", field_names[k],
                            res_item[$bits(dcc_res_item_t) - 1 - k],
                            want[$bits(dcc_res_item_t) - 1 - k]));
            end
        end
    end

    task automatic queue_cmd(logic [2:0] c, logic [7:0] n, logic [3:0] fi, logic fo);
        dcc_cmd_item_t it;
        it.cmd = c;
        it.repeat_count = n;
        it.func_index = fi;
        it.func_on = fo;
        pending_cmds.push_back(it);
    endtask

    task automatic queue_ticks(int count);
        repeat (count)
            queue_cmd(CMD_TICK, 8'($urandom), 4'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd_valid || expected_res.size() != 0)
            @(posedge clk);
    endtask

    // tick until the line model reports no packets left
    task automatic finish_packets();
        wait_drained();
        while (reps_left != 0)
        begin
            queue_ticks(TICK_CHUNK);
            wait_drained();
        end
    endtask

    task automatic write_reg(dcc_reg_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LOCO_ADDRESS:   cfg.loco_address = val[7:0];
            REG_SPEED_SELECT:   cfg.speed_select = val[0];
            REG_TURNOUT_SWAP:   cfg.turnout_swap = val[0];
            REG_ONE_HALF_TICKS: cfg.one_half_ticks = val;
            default:            cfg.zero_half_ticks = val;
        endcase
    endtask

    task automatic set_config(dcc_cfg_t c);
        @(posedge clk);
        write_reg(REG_LOCO_ADDRESS, 16'(c.loco_address));
        write_reg(REG_SPEED_SELECT, 16'(c.speed_select));
        write_reg(REG_TURNOUT_SWAP, 16'(c.turnout_swap));
        write_reg(REG_ONE_HALF_TICKS, c.one_half_ticks);
        write_reg(REG_ZERO_HALF_TICKS, c.zero_half_ticks);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        dcc_cfg_t c;
        int r;
        int waited;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: no packets, only idle effects and function bits
        queue_cmd(CMD_TICK, 8'd1, 4'd0, 1'b0);
        queue_cmd(CMD_SPARE_LO, 8'd1, 4'd0, 1'b1);
        queue_cmd(CMD_SPARE_HI, 8'd255, 4'd15, 1'b1);
        queue_cmd(CMD_FUNC, 8'd0, 4'd0, 1'b1);
        queue_cmd(CMD_FUNC, 8'd0, 4'd4, 1'b0);
        queue_cmd(CMD_FUNC, 8'd0, 4'd5, 1'b1);
        queue_cmd(CMD_FUNC, 8'd0, 4'd8, 1'b0);
        queue_cmd(CMD_FUNC, 8'd0, 4'd9, 1'b1);
        queue_cmd(CMD_FUNC, 8'd0, 4'd15, 1'b0);
        wait_drained();

        set_config('{8'd0, 1'b0, 1'b0, 16'd1, 16'd2});
        queue_cmd(CMD_FORWARD, 8'd1, 4'd0, 1'b0);
        queue_cmd(CMD_STOP, 8'd200, 4'd3, 1'b1);
        finish_packets();

        set_config('{8'd255, 1'b1, 1'b1, 16'd0, 16'd0});
        queue_cmd(CMD_BACKWARD, 8'd2, 4'd0, 1'b0);
        queue_cmd(CMD_FUNC, 8'd1, 4'd2, 1'b1);
        finish_packets();
        queue_cmd(CMD_FUNC, 8'd0, 4'd12, 1'b0);
        queue_cmd(CMD_SPARE_HI, 8'd3, 4'd1, 1'b1);
        queue_cmd(CMD_IDLE, 8'd0, 4'd0, 1'b0);
        queue_cmd(CMD_FUNC, 8'd0, 4'd7, 1'b1);
        finish_packets();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            c.loco_address = 8'($urandom);
            c.speed_select = 1'($urandom);
            c.turnout_swap = 1'($urandom);
            c.one_half_ticks = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 2));
            c.zero_half_ticks = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 2));
            set_config(c);
            if (ph == HOLD_PHASE)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 84)
                    queue_ticks(1);
                else if (r < 98)
                    queue_cmd(3'($urandom_range(CMD_FORWARD, CMD_FUNC)),
                        8'($urandom_range(0, 1)),
                        ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
                        1'($urandom));
                else
                    queue_cmd(($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI,
                        8'($urandom), 4'($urandom), 1'($urandom));
            end
            finish_packets();
        end

        // longest zero half period: run through the preamble into the first start bit
        c.loco_address = 8'($urandom);
        c.speed_select = 1'($urandom);
        c.turnout_swap = 1'($urandom);
        c.one_half_ticks = 16'd1;
        c.zero_half_ticks = 16'hFFFF;
        set_config(c);
        queue_cmd(CMD_FORWARD, 8'd1, 4'd0, 1'b0);
        queue_ticks(LAST_PHASE_TICKS);

        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        waited = 0;
        while (expected_res.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (expected_res.size() != 0)
            report_error($sformatf("%0d result items never arrived", expected_res.size()));
        if (error_count == 0)
            $display("dcc_packet_line_encoder test passed");
        else
            $display("dcc_packet_line_encoder test failed");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("dcc_packet_line_encoder test failed");
        $finish;
    end

endmodule
